[rtl/tksp_pkg.sv]
// shared types and constants for the streaming top-k sum block
package tksp_pkg;

    localparam int unsigned HeapDepthDefault = 1024;
    localparam int unsigned CountWidth = 11;
    localparam int unsigned PenaltyWidth = 31;
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned EntryWidth = 31;
    localparam int unsigned OutWidth = 42;
    localparam int unsigned SumWidth = 64;
    localparam int unsigned IndexWidth = 32;
    localparam int unsigned CostWidth = 63;

    // configuration register indexes
    localparam logic CfgKeepCount = 1'b0;
    localparam logic CfgPenalty = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_UP_READ,
        ST_UP_STEP,
        ST_DN_READ,
        ST_DN_STEP,
        ST_SCORE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decide;
        logic up_read;
        logic up_step;
        logic dn_read;
        logic dn_step;
        logic score;
        logic emit;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic do_insert;
        logic do_replace;
        logic up_done;
        logic up_stop;
        logic dn_done;
        logic dn_stop;
        logic out_busy;
    } status_t;

endpackage

[rtl/tksp_ram.sv]
// generic ram with one write port and one registered read port
module tksp_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/tksp_ctrl.sv]
// controller state machine for the heap update sequence
module tksp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tksp_pkg::status_t status,
    output tksp_pkg::cmd_t    cmd
);

    tksp_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tksp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tksp_pkg::ST_IDLE: begin
                if (s_valid) state_next = tksp_pkg::ST_DECIDE;
            end
            tksp_pkg::ST_DECIDE: begin
                priority if (status.skip) state_next = tksp_pkg::ST_OUT;
                else if (status.do_insert) state_next = tksp_pkg::ST_UP_READ;
                else if (status.do_replace) state_next = tksp_pkg::ST_DN_READ;
                else state_next = tksp_pkg::ST_SCORE;
            end
            tksp_pkg::ST_UP_READ: begin
                if (status.up_done) state_next = tksp_pkg::ST_SCORE;
                else state_next = tksp_pkg::ST_UP_STEP;
            end
            tksp_pkg::ST_UP_STEP: begin
                if (status.up_stop) state_next = tksp_pkg::ST_SCORE;
                else state_next = tksp_pkg::ST_UP_READ;
            end
            tksp_pkg::ST_DN_READ: begin
                if (status.dn_done) state_next = tksp_pkg::ST_SCORE;
                else state_next = tksp_pkg::ST_DN_STEP;
            end
            tksp_pkg::ST_DN_STEP: begin
                if (status.dn_stop) state_next = tksp_pkg::ST_SCORE;
                else state_next = tksp_pkg::ST_DN_READ;
            end
            tksp_pkg::ST_SCORE: state_next = tksp_pkg::ST_OUT;
            tksp_pkg::ST_OUT: begin
                if (!status.out_busy) state_next = tksp_pkg::ST_IDLE;
            end
            default: state_next = tksp_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            tksp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
            end
            tksp_pkg::ST_DECIDE: cmd.decide = 1'b1;
            tksp_pkg::ST_UP_READ: cmd.up_read = 1'b1;
            tksp_pkg::ST_UP_STEP: cmd.up_step = 1'b1;
            tksp_pkg::ST_DN_READ: cmd.dn_read = 1'b1;
            tksp_pkg::ST_DN_STEP: cmd.dn_step = 1'b1;
            tksp_pkg::ST_SCORE: cmd.score = 1'b1;
            tksp_pkg::ST_OUT: begin
                cmd.emit = !status.out_busy;
                cmd.finish = !status.out_busy;
            end
            default: ;
        endcase
    end

endmodule

[rtl/tksp_dp.sv]
// datapath: heap memory, sift unit, sum, penalty and score
module tksp_dp #(
    parameter int unsigned HEAP_DEPTH = tksp_pkg::HeapDepthDefault
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [tksp_pkg::PenaltyWidth-1:0]    cfg_data,
    input  logic signed [tksp_pkg::ValueWidth-1:0] s_value,
    input  logic                                 s_last_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tksp_pkg::OutWidth-1:0]        m_best_score,
    output logic [tksp_pkg::OutWidth-1:0]        m_kept_sum,
    output logic                                 m_final_res,
    input  tksp_pkg::cmd_t                       cmd,
    output tksp_pkg::status_t                    status
);

    localparam int unsigned AW = $clog2(HEAP_DEPTH);
    localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned EW = tksp_pkg::EntryWidth;
    localparam int unsigned SW = tksp_pkg::SumWidth;
    localparam int unsigned OW = tksp_pkg::OutWidth;
    localparam int unsigned KW = tksp_pkg::CountWidth;

    // configuration
    logic [KW-1:0] keep_count_reg;
    logic [tksp_pkg::PenaltyWidth-1:0] penalty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_count_reg <= KW'(1);
            penalty_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == tksp_pkg::CfgKeepCount) keep_count_reg <= cfg_data[KW-1:0];
            else penalty_reg <= cfg_data;
        end
    end

    // sequence state
    logic [CW-1:0] count_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] best_reg;
    logic [tksp_pkg::IndexWidth-1:0] index_reg;
    logic [EW-1:0] val_reg;
    logic neg_reg, last_reg;
    logic [CW-1:0] pos_reg;
    logic [AW-1:0] kid_reg;
    logic [1:0] phase_reg;
    logic [EW-1:0] kid_val_reg;
    logic [tksp_pkg::CostWidth-1:0] cost_reg;

    // ram ports
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    tksp_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // effective keep limit
    logic [CW:0] limit;
    always_comb begin
        if ({1'b0, keep_count_reg} > (KW+1)'(HEAP_DEPTH) && KW >= CW) limit = (CW+1)'(HEAP_DEPTH);
        else if (32'(keep_count_reg) > HEAP_DEPTH) limit = (CW+1)'(HEAP_DEPTH);
        else limit = (CW+1)'(keep_count_reg);
    end

    // sift helpers
    logic [CW:0] up_parent;
    logic [CW:0] left_kid, right_kid;
    assign up_parent = ({1'b0, pos_reg} - 1'b1) >> 1;
    assign left_kid = {pos_reg, 1'b1};
    assign right_kid = left_kid + 1'b1;

    // root is on the read port while deciding
    assign status.skip = neg_reg;
    assign status.do_insert = !neg_reg && ({1'b0, count_reg} < limit);
    assign status.do_replace = !neg_reg && (count_reg != '0) && (val_reg > ram_rdata);
    assign status.up_done = (pos_reg == '0);
    assign status.up_stop = !(ram_rdata > val_reg);
    assign status.dn_done = (left_kid >= {1'b0, count_reg});
    assign status.dn_stop = (phase_reg == 2'd2) && !(kid_val_reg < val_reg);
    assign status.out_busy = m_valid && !m_ready;

    // downward walk: phase 0 reads left, phase 1 reads right
    logic right_ok;
    assign right_ok = right_kid < {1'b0, count_reg};

    // memory port control
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = pos_reg[AW-1:0];
        ram_wdata = val_reg;
        ram_raddr = '0;
        if (cmd.load) begin
            ram_raddr = '0;
        end else if (cmd.up_read) begin
            ram_raddr = up_parent[AW-1:0];
            if (status.up_done) ram_we = 1'b1;
        end else if (cmd.up_step) begin
            ram_we = 1'b1;
            if (ram_rdata > val_reg) ram_wdata = ram_rdata;
        end else if (cmd.dn_read) begin
            ram_raddr = (phase_reg == 2'd0) ? left_kid[AW-1:0] : right_kid[AW-1:0];
            if (status.dn_done && phase_reg == 2'd0) ram_we = 1'b1;
        end else if (cmd.dn_step && phase_reg == 2'd2) begin
            ram_we = 1'b1;
            if (kid_val_reg < val_reg) ram_wdata = kid_val_reg;
        end
    end

    // datapath registers
    logic [SW-1:0] sum_after;
    assign sum_after = sum_reg + SW'(val_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg <= '0;
            best_reg <= '0;
            index_reg <= '0;
            m_valid <= 1'b0;
            phase_reg <= '0;
        end else begin
            if (cmd.load) begin
                val_reg <= s_value[EW-1:0];
                neg_reg <= s_value[tksp_pkg::ValueWidth-1];
                last_reg <= s_last_item;
                if (index_reg != '1) index_reg <= index_reg + 1'b1;
            end
            if (cmd.decide) begin
                phase_reg <= '0;
                if (status.do_insert) begin
                    pos_reg <= count_reg;
                    count_reg <= count_reg + 1'b1;
                    sum_reg <= sum_after;
                end else if (status.do_replace) begin
                    pos_reg <= '0;
                    sum_reg <= sum_after - SW'(ram_rdata);
                end
                cost_reg <= penalty_reg * index_reg;
            end
            if (cmd.up_step) begin
                if (ram_rdata > val_reg) pos_reg <= up_parent[CW-1:0];
                else pos_reg <= '0;
            end
            if (cmd.dn_step) begin
                unique case (phase_reg)
                    2'd0: begin
                        kid_val_reg <= ram_rdata;
                        kid_reg <= left_kid[AW-1:0];
                        phase_reg <= right_ok ? 2'd1 : 2'd2;
                    end
                    2'd1: begin
                        if (ram_rdata < kid_val_reg) begin
                            kid_val_reg <= ram_rdata;
                            kid_reg <= right_kid[AW-1:0];
                        end
                        phase_reg <= 2'd2;
                    end
                    default: begin
                        phase_reg <= '0;
                        if (kid_val_reg < val_reg) pos_reg <= CW'(kid_reg);
                        else pos_reg <= CW'(HEAP_DEPTH);
                    end
                endcase
            end
            if (cmd.score) begin
                if (sum_reg > SW'(cost_reg) && sum_reg - SW'(cost_reg) > best_reg)
                    best_reg <= sum_reg - SW'(cost_reg);
            end
            if (!cmd.emit && m_valid && m_ready) m_valid <= 1'b0;
            if (cmd.emit) begin
                m_valid <= 1'b1;
                m_best_score <= (best_reg > SW'({OW{1'b1}})) ? {OW{1'b1}} : best_reg[OW-1:0];
                m_kept_sum <= (sum_reg > SW'({OW{1'b1}})) ? {OW{1'b1}} : sum_reg[OW-1:0];
                m_final_res <= last_reg;
                if (last_reg) begin
                    count_reg <= '0;
                    sum_reg <= '0;
                    best_reg <= '0;
                    index_reg <= '0;
                end
            end
        end
    end

endmodule

[rtl/streaming_top_k_sum_with_penalty_core.sv]
// top level of the streaming top-k sum with penalty block
// Each request takes one signed value and gives one result with the best
// score and the sum of the largest keep_count non-negative values, with
// keep_count capped at the heap depth. Requests are handled one at a time:
// a negative value skips the heap and the score, a value that changes
// nothing goes straight to the score, an insert sifts the new value up from
// the end of the heap, and a replace of the minimum sifts it down from the
// root, reading the left and then the right child (where there is one) at
// each level; the registered read of the heap memory paces these walks. The
// result register lets the next request start while a result waits.
module streaming_top_k_sum_with_penalty_core #(
    parameter int unsigned HEAP_DEPTH = tksp_pkg::HeapDepthDefault
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_index,
    input  logic [tksp_pkg::PenaltyWidth-1:0]      cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [tksp_pkg::ValueWidth-1:0] s_value,
    input  logic                                   s_last_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [tksp_pkg::OutWidth-1:0]          m_best_score,
    output logic [tksp_pkg::OutWidth-1:0]          m_kept_sum,
    output logic                                   m_final_res
);

    tksp_pkg::cmd_t cmd;
    tksp_pkg::status_t status;

    // controller
    tksp_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    // datapath
    tksp_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_value     (s_value),
        .s_last_item (s_last_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_best_score(m_best_score),
        .m_kept_sum  (m_kept_sum),
        .m_final_res (m_final_res),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

[tb/tb_streaming_top_k_sum_with_penalty_core.sv]
// testbench for the streaming top-k sum with penalty block
`timescale 1ns / 1ps

// predicts and checks the score and sum results
class topk_score_board;
    int unsigned keep_limit;
    int unsigned cost_per_item;
    bit [30:0] min_heap[tksp_pkg::HeapDepthDefault];
    int unsigned heap_fill;
    bit [63:0] sum_kept;
    bit [63:0] best_so_far;
    bit [31:0] item_count;
    bit [84:0] pending_scores[$];
    int unsigned mismatch_count;

    function void clear_sequence();
        heap_fill = 0;
        sum_kept = 0;
        best_so_far = 0;
        item_count = 0;
    endfunction

    function void reset_state();
        clear_sequence();
        keep_limit = 1;
        cost_per_item = 0;
        mismatch_count = 0;
        pending_scores.delete();
    endfunction

    function void set_register(logic idx, bit [30:0] data);
        if (idx == tksp_pkg::CfgKeepCount) keep_limit = data[10:0];
        else cost_per_item = data;
    endfunction

    function void push_value(bit [30:0] v);
        int unsigned pos;
        int unsigned up;
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
            up = (pos - 1) >> 1;
            if (min_heap[up] <= v) break;
            min_heap[pos] = min_heap[up];
            pos = up;
        end
        min_heap[pos] = v;
    endfunction

    function void replace_min(bit [30:0] v);
        int unsigned pos;
        int unsigned kid;
        pos = 0;
        forever begin
            kid = 2 * pos + 1;
            if (kid >= heap_fill) break;
            if (kid + 1 < heap_fill && min_heap[kid + 1] < min_heap[kid]) kid++;
            if (min_heap[kid] >= v) break;
            min_heap[pos] = min_heap[kid];
            pos = kid;
        end
        min_heap[pos] = v;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(bit [31:0] raw, bit last);
        int unsigned lim;
        bit [63:0] cost;
        bit [41:0] best_out;
        bit [41:0] sum_out;
        lim = keep_limit > tksp_pkg::HeapDepthDefault ? tksp_pkg::HeapDepthDefault : keep_limit;
        if (item_count != 32'hFFFF_FFFF) item_count++;
        if (!raw[31]) begin
            if (heap_fill < lim) begin
                push_value(raw[30:0]);
                sum_kept += raw;
            end else if (heap_fill > 0 && raw[30:0] > min_heap[0]) begin
                sum_kept = sum_kept - min_heap[0] + raw;
                replace_min(raw[30:0]);
            end
            cost = 64'(cost_per_item) * 64'(item_count);
            if (sum_kept > cost && sum_kept - cost > best_so_far)
                best_so_far = sum_kept - cost;
        end
        best_out = best_so_far > 64'h3FF_FFFF_FFFF ? '1 : best_so_far[41:0];
        sum_out = sum_kept > 64'h3FF_FFFF_FFFF ? '1 : sum_kept[41:0];
        pending_scores.push_back({best_out, sum_out, last});
        if (last) clear_sequence();
    endfunction

    // compare one result with the oldest expectation
    function void check_result(bit [41:0] best, bit [41:0] sum, bit fin);
        bit [84:0] want;
        if (pending_scores.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result best=%0d sum=%0d", best, sum);
            return;
        end
        want = pending_scores.pop_front();
        if (want != {best, sum, fin}) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: exp best=%0d sum=%0d fin=%0b, got best=%0d sum=%0d fin=%0b",
                         want[84:43], want[42:1], want[0], best, sum, fin);
        end
    endfunction
endclass

module tb_streaming_top_k_sum_with_penalty_core;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = tksp_pkg::CfgKeepCount;
    logic [30:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_value = '0;
    logic        s_last_item = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [41:0] m_best_score;
    logic [41:0] m_kept_sum;
    logic        m_final_res;

    topk_score_board board;
    bit          idle_allowed = 1'b1;
    bit          hold_results = 1'b0;
    int          leftover;

    streaming_top_k_sum_with_penalty_core dut (.*);

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // sample results
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_best_score, m_kept_sum, m_final_res);
    end

    // receiver with random stall bursts
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_results) m_ready <= 1'b0;
            else if (idle_allowed && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge aclk);
            end else m_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic idx, bit [30:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_register(idx, data);
    endtask

    // stop offering and wait for every expected result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending_scores.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    // offer one request, with an optional random gap first
    task automatic send_request(bit [31:0] v, bit last);
        int n;
        if (idle_allowed && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last_item <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_request(v, last);
        @(negedge aclk);
    endtask

    function automatic bit [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {1'b0, 31'($urandom())};
            2: return $urandom_range(0, 50);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return {1'b0, 31'($urandom_range(0, 100000))};
        endcase
    endfunction

    task automatic random_phase(int count, int seq_max);
        int len;
        while (count > 0) begin
            len = $urandom_range(1, seq_max);
            for (int i = 0; i < len && count > 0; i++) begin
                send_request(rand_value(), i == len - 1 || count == 1);
                count--;
            end
        end
    endtask

    initial begin
        board = new();
        board.reset_state();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: default registers, extremes and negative values
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h7FFF_FFFF, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'd5, 1'b1);
        wait_drained();

        // zero keep count with a penalty
        write_reg(tksp_pkg::CfgKeepCount, 31'd0);
        write_reg(tksp_pkg::CfgPenalty, 31'd3);
        send_request(32'd100, 1'b0);
        send_request(32'h5555_5555, 1'b1);
        wait_drained();

        // keep four, fill then replace the minimum
        write_reg(tksp_pkg::CfgKeepCount, 31'd4);
        write_reg(tksp_pkg::CfgPenalty, 31'd10);
        for (int i = 0; i < 8; i++) send_request(32'(i * 37 % 11 + 20), 1'b0);
        send_request(32'hAAAA_AAAA, 1'b0);
        wait_drained();

        // lowered keep count mid sequence: heap stays larger
        write_reg(tksp_pkg::CfgKeepCount, 31'd2);
        send_request(32'd1000, 1'b0);
        send_request(32'd1, 1'b1);
        wait_drained();

        // maximum penalty and oversized keep count
        write_reg(tksp_pkg::CfgKeepCount, 31'h7FF);
        write_reg(tksp_pkg::CfgPenalty, 31'h7FFF_FFFF);
        random_phase(40, 40);
        wait_drained();

        // long receiver hold-off while requests keep coming
        write_reg(tksp_pkg::CfgKeepCount, 31'd8);
        write_reg(tksp_pkg::CfgPenalty, 31'd0);
        fork
            begin
                hold_results = 1'b1;
                repeat (300) @(negedge aclk);
                hold_results = 1'b0;
            end
            random_phase(20, 20);
        join
        wait_drained();

        // random phases across settings
        write_reg(tksp_pkg::CfgKeepCount, 31'd1024);
        write_reg(tksp_pkg::CfgPenalty, 31'd1);
        random_phase(150, 200);
        wait_drained();
        write_reg(tksp_pkg::CfgKeepCount, 31'd16);
        write_reg(tksp_pkg::CfgPenalty, 31'($urandom_range(0, 1000000)));
        random_phase(150, 30);
        wait_drained();
        write_reg(tksp_pkg::CfgKeepCount, 31'd3);
        write_reg(tksp_pkg::CfgPenalty, 31'd50);
        random_phase(120, 12);

        // final stretch without idling
        idle_allowed = 1'b0;
        random_phase(100, 25);
        s_valid <= 1'b0;

        leftover = 0;
        while (board.pending_scores.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        leftover = board.pending_scores.size();
        if (board.mismatch_count == 0 && leftover == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
